// File: design/mecanum_field_centric_ik_core_assert.svh
// assertion macros for the field-centric mecanum core
`ifndef MECANUM_FIELD_CENTRIC_IK_CORE_ASSERT_SVH
`define MECANUM_FIELD_CENTRIC_IK_CORE_ASSERT_SVH
// property must hold on every clock edge out of reset
`define MFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define MFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/mfcik_pkg.sv
// shared types and constants for the field-centric mecanum core
package mfcik_pkg;
    localparam int unsigned NSTEP = 16;
    localparam int unsigned VW = 28;     // cordic x/y width, Q1.22 plus growth
    localparam int unsigned ZW = 34;     // angle accumulator width
    localparam int unsigned WW = 19;     // wheel sum width
    localparam int unsigned MW = 18;     // magnitude width
    localparam int unsigned QW = 16;     // quotient width
    localparam int unsigned QB = 15;     // quotient bits produced, one per divider cell
    localparam logic [16:0] INV_GAIN = 17'd39797;
    localparam logic [MW-1:0] WHEEL_ONE = 18'd16384;

    typedef logic [ZW-1:0] t_atan_tab [NSTEP];
    localparam t_atan_tab ATAN_TAB = '{
        34'd536870912, 34'd316933406, 34'd167458907, 34'd85004756,
        34'd42667331, 34'd21354465, 34'd10679838, 34'd5340245,
        34'd2670163, 34'd1335087, 34'd667544, 34'd333772,
        34'd166886, 34'd83443, 34'd41722, 34'd20861
    };

    // payload that walks through the cordic chain
    typedef struct packed {
        logic                    vld;
        logic signed [VW-1:0]    x;
        logic signed [VW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic signed [15:0]      rot;
    } t_crd;

    // payload that walks through the divider chain
    typedef struct packed {
        logic                    vld;
        logic                    scl;
        logic [3:0]              neg;
        logic [MW-1:0]           m;     // divisor
        logic [4*MW-1:0]         rem;   // partial remainders
        logic [4*QW-1:0]         quo;   // quotients so far
    } t_div;
endpackage

// File: design/mfcik_cordic_cell.sv
// one cordic micro-rotation cell with its own register
module mfcik_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mfcik_pkg::t_crd i_d,
    output mfcik_pkg::t_crd o_d
);
    mfcik_pkg::t_crd r_d, n_d;
    logic signed [mfcik_pkg::VW-1:0] dx, dy;

    always_comb begin
        dx = i_d.x >>> STEP;
        dy = i_d.y >>> STEP;
        n_d = i_d;
        if (!i_d.z[mfcik_pkg::ZW-1]) begin
            n_d.x = i_d.x - dy;
            n_d.y = i_d.y + dx;
            n_d.z = i_d.z - $signed(mfcik_pkg::ATAN_TAB[STEP]);
        end else begin
            n_d.x = i_d.x + dy;
            n_d.y = i_d.y - dx;
            n_d.z = i_d.z + $signed(mfcik_pkg::ATAN_TAB[STEP]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= i_d.vld;
        end
        if (i_en) begin
            r_d.x   <= n_d.x;
            r_d.y   <= n_d.y;
            r_d.z   <= n_d.z;
            r_d.rot <= n_d.rot;
        end
    end

    assign o_d = r_d;
endmodule

// File: design/mfcik_div_cell.sv
// one restoring-division bit cell working on four wheels at once
module mfcik_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mfcik_pkg::t_div i_d,
    output mfcik_pkg::t_div o_d
);
    localparam int unsigned MW = mfcik_pkg::MW;
    localparam int unsigned QW = mfcik_pkg::QW;
    mfcik_pkg::t_div r_d, n_d;
    logic [MW:0] trial;

    // first cell compares the magnitude itself, later cells shift in a zero
    always_comb begin
        n_d = i_d;
        trial = '0;
        for (int k = 0; k < 4; k++) begin
            if (FIRST) begin
                trial = {1'b0, i_d.rem[k*MW +: MW]};
            end else begin
                trial = {i_d.rem[k*MW +: MW], 1'b0};
            end
            if (trial >= {1'b0, i_d.m}) begin
                n_d.rem[k*MW +: MW] = MW'(trial - {1'b0, i_d.m});
                n_d.quo[k*QW +: QW] = {i_d.quo[k*QW +: QW-1], 1'b1};
            end else begin
                n_d.rem[k*MW +: MW] = MW'(trial);
                n_d.quo[k*QW +: QW] = {i_d.quo[k*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d.vld <= i_d.vld;
        end
        if (i_en) begin
            r_d.scl <= n_d.scl;
            r_d.neg <= n_d.neg;
            r_d.m   <= n_d.m;
            r_d.rem <= n_d.rem;
            r_d.quo <= n_d.quo;
        end
    end

    assign o_d = r_d;
endmodule

// File: design/mecanum_field_centric_ik_core.sv
// top level: field-centric mecanum inverse kinematics
//  channel | handshake        | fields
//  in      | i_valid/o_ready  | strafe, drive, rotate, heading
//  out     | o_valid/i_ready  | lf, rf, lb, rb wheel commands, was_scaled
// a word can enter every cycle while the output is not stalled; 35 register
// stages: 16 cordic cells, gain, wheel mix, divisor select, 15 divider cells
// and the output register
// the whole row of cells advances together; a stall on the output
// freezes every cell, and o_ready follows only i_ready and the output reg
// reset (synchronous, active low) clears only the valid bits
`include "mecanum_field_centric_ik_core_assert.svh"
module mecanum_field_centric_ik_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_strafe_in,
    input  logic signed [15:0] i_drive_in,
    input  logic signed [15:0] i_rotate_in,
    input  logic [15:0]        i_heading_angle,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_lf_cmd,
    output logic signed [15:0] o_rf_cmd,
    output logic signed [15:0] o_lb_cmd,
    output logic signed [15:0] o_rb_cmd,
    output logic               o_was_scaled
);
    localparam int unsigned NS = mfcik_pkg::NSTEP;
    localparam int unsigned VW = mfcik_pkg::VW;
    localparam int unsigned ZW = mfcik_pkg::ZW;
    localparam int unsigned WW = mfcik_pkg::WW;
    localparam int unsigned MW = mfcik_pkg::MW;
    localparam int unsigned QW = mfcik_pkg::QW;
    localparam int unsigned QB = mfcik_pkg::QB;

    // the whole chain moves when the output register is free
    logic adv;
    assign adv = !o_valid || i_ready;
    assign o_ready = adv;

    // quadrant fold in front of the cordic chain
    mfcik_pkg::t_crd crd [NS+1];
    mfcik_pkg::t_crd crd_in;
    logic signed [15:0] a0;
    logic signed [VW-1:0] x0, y0;
    logic signed [16:0] af;
    always_comb begin
        a0 = $signed(i_heading_angle);
        x0 = VW'($signed({i_strafe_in, 8'd0}));
        y0 = VW'($signed({i_drive_in, 8'd0}));
        af = 17'(a0);
        // headings beyond a quarter turn: flip the vector, fold the angle
        if (a0 > 16'sd16384) begin
            x0 = -x0; y0 = -y0; af = af - 17'sd32768;
        end else if (a0 < -16'sd16384) begin
            x0 = -x0; y0 = -y0; af = af + 17'sd32768;
        end
        crd_in.vld = i_valid;
        crd_in.x   = x0;
        crd_in.y   = y0;
        crd_in.z   = ZW'($signed({af, 16'd0}));
        crd_in.rot = i_rotate_in;
    end
    assign crd[0] = crd_in;

    for (genvar s = 0; s < NS; s++) begin : g_crd
        mfcik_cordic_cell #(.STEP(s)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_d(crd[s]), .o_d(crd[s+1])
        );
    end

    // gain stage: one multiply per axis, registered, rounding offset added
    logic signed [VW+17:0] r_gx, r_gy;
    logic signed [15:0]    r_grot;
    logic                  r_gv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (adv) begin
            r_gv <= crd[NS].vld;
        end
        if (adv) begin
            r_gx   <= (VW+18)'(crd[NS].x * $signed({1'b0, mfcik_pkg::INV_GAIN}))
                      + (VW+18)'(1 << 23);
            r_gy   <= (VW+18)'(crd[NS].y * $signed({1'b0, mfcik_pkg::INV_GAIN}))
                      + (VW+18)'(1 << 23);
            r_grot <= crd[NS].rot;
        end
    end

    // wheel mix stage: forward is the negated turned drive
    logic signed [WW-1:0] xr, yr, fwd, rt, rot;
    logic signed [WW-1:0] n_w [4];
    logic signed [WW-1:0] r_w [4];
    logic                 r_wv;
    always_comb begin
        xr  = WW'(r_gx >>> 24);
        yr  = WW'(r_gy >>> 24);
        fwd = -yr;
        rt  = xr;
        rot = WW'(r_grot);
        n_w[0] = fwd + rot + rt;
        n_w[1] = fwd - rot - rt;
        n_w[2] = fwd + rot - rt;
        n_w[3] = fwd - rot + rt;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else if (adv) begin
            r_wv <= r_gv;
        end
        if (adv) begin
            r_w <= n_w;
        end
    end

    // magnitudes, max and divisor select
    // unscaled words divide by one (16384), which returns the magnitude as is
    logic [MW-1:0] mag [4];
    logic [MW-1:0] m01, m23, mx;
    logic          scl;
    mfcik_pkg::t_div div [QB+1];
    mfcik_pkg::t_div r_d0;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag[k] = r_w[k][WW-1] ? MW'(-r_w[k]) : MW'(r_w[k]);
        end
        m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
        m23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
        mx  = (m01 > m23) ? m01 : m23;
        scl = mx > mfcik_pkg::WHEEL_ONE;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0.vld <= 1'b0;
        end else if (adv) begin
            r_d0.vld <= r_wv;
        end
        if (adv) begin
            r_d0.scl <= scl;
            r_d0.m   <= scl ? mx : mfcik_pkg::WHEEL_ONE;
            r_d0.quo <= '0;
            for (int k = 0; k < 4; k++) begin
                r_d0.neg[k] <= r_w[k][WW-1];
                r_d0.rem[k*MW +: MW] <= mag[k];
            end
        end
    end
    assign div[0] = r_d0;

    // quotient = mag * 16384 / m with mag <= m; first cell gives the
    // integer bit, the other 14 the fraction bits
    for (genvar b = 0; b < QB; b++) begin : g_div
        mfcik_div_cell #(.FIRST(b == 0)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
            .i_d(div[b]), .o_d(div[b+1])
        );
    end

    // output register with sign restore and right-side negation
    logic [QW-1:0] q [4];
    logic signed [15:0] cmd [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            q[k] = div[QB].quo[k*QW +: QW];
            cmd[k] = div[QB].neg[k] ? -$signed(q[k]) : $signed(q[k]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= div[QB].vld;
        end
        if (adv) begin
            o_lf_cmd     <= cmd[0];
            o_rf_cmd     <= -cmd[1];
            o_lb_cmd     <= cmd[2];
            o_rb_cmd     <= -cmd[3];
            o_was_scaled <= div[QB].scl;
        end
    end

    logic stall, lf_ok;
    assign stall = o_valid && !i_ready;
    assign lf_ok = (o_lf_cmd <= 16'sd16384) && (o_lf_cmd >= -16'sd16384);

    `MFC_ASSERT(a_rdy, i_clk, i_rst_n, o_ready == (!o_valid || i_ready), "ready mismatch")
    `MFC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, o_valid && $stable(o_lf_cmd), "not held")
    `MFC_ASSERT(a_rng, i_clk, i_rst_n, !o_valid || lf_ok, "wheel out of range")
endmodule
